FILE: hdl/cic_pkg.sv
package cic_pkg;

  localparam int ALPHA_W = 13;

  localparam logic [ALPHA_W-1:0] POT_ALPHA = 13'd1311;
  localparam logic [ALPHA_W-1:0] CV1_ALPHA = 13'd3277;
  localparam logic [ALPHA_W-1:0] CV2_ALPHA = 13'd6554;

  localparam logic signed [16:0] VOLT_OFFSET  = 17'sd20852;
  localparam logic [15:0]        MOVE_LIMIT   = 16'd655;
  localparam logic [18:0]        SAMPLES_MAX  = 19'd524287;
  localparam logic [18:0]        INTERVAL_RST = 19'd24000;
  localparam logic signed [25:0] CV_BIAS      = 26'sd5242880;
  localparam logic [19:0]        RECIP5       = 20'd838861;
  localparam logic [25:0]        RECIP125     = 26'd34359738;
  localparam logic [25:0]        DIV_STEP     = 26'd125;
  localparam logic [34:0]        ROUND_HALF   = 35'd500;
  localparam logic [34:0]        SAT_LIMIT    = 35'd524288000;

  localparam logic [2:0] REG_SAMPLE_RATE  = 3'd0;
  localparam logic [2:0] REG_TAKEOVER_ON  = 3'd1;
  localparam logic [2:0] REG_TAKEOVER_OFF = 3'd2;
  localparam logic [2:0] REG_TAP_HIGH     = 3'd3;
  localparam logic [2:0] REG_TAP_LOW      = 3'd4;
  localparam logic [2:0] REG_TAP_MIN      = 3'd5;
  localparam logic [2:0] REG_TAP_MAX      = 3'd6;
  localparam logic [2:0] REG_TAP_TIMEOUT  = 3'd7;

  localparam logic [15:0] THIRD_TABLE [0:15] = '{
    16'd32768, 16'd32768, 16'd39322, 16'd32768,
    16'd26214, 16'd22938, 16'd19661, 16'd29491,
    16'd19661, 16'd0,     16'd26214, 16'd32768,
    16'd45875, 16'd32768, 16'd52429, 16'd32768
  };

  typedef struct packed {
    logic [15:0] high;
    logic [15:0] low;
    logic [15:0] min_ms;
    logic [15:0] max_ms;
    logic [15:0] timeout_ms;
  } tap_cfg_t;

  typedef struct packed {
    logic        cap;
    logic [15:0] dt;
    logic        valid;
  } tap_res_t;

  // 5.0909 V minus 10 V times code/65536, Q12
  function automatic logic signed [16:0] code_to_volts(input logic [15:0] code);
    logic [18:0] t;
    t = {3'b000, code} * 19'd5 + 19'd4;
    return VOLT_OFFSET - $signed({1'b0, t[18:3]});
  endfunction

endpackage

FILE: hdl/cic_iir.sv
module cic_iir (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              upd,
  input  logic signed [24:0]                x,
  input  logic        [cic_pkg::ALPHA_W-1:0] alpha,
  output logic signed [24:0]                s_r
);
  import cic_pkg::*;

  logic signed [25:0] diff;
  logic signed [39:0] prod;
  logic        [38:0] mag;
  logic        [38:0] sum;
  logic        [22:0] inc;
  logic signed [24:0] s_nxt;

  assign diff  = {x[24], x} - {s_r[24], s_r};
  assign prod  = diff * $signed({1'b0, alpha});
  assign mag   = prod[39] ? 39'(-prod) : prod[38:0];
  assign sum   = mag + 39'd32768;
  assign inc   = sum[38:16];
  assign s_nxt = prod[39] ? s_r - $signed({2'b00, inc}) : s_r + $signed({2'b00, inc});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r <= '0;
    end else if (upd) begin
      s_r <= s_nxt;
    end
  end

endmodule

FILE: hdl/cic_tap.sv
module cic_tap (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              upd,
  input  logic              bank_one,
  input  logic signed [16:0] raw,
  input  logic       [31:0] now_ms,
  input  cic_pkg::tap_cfg_t cfg,
  output cic_pkg::tap_res_t res_r
);
  import cic_pkg::*;

  logic        gate_r;
  logic [31:0] last_r;
  logic [31:0] dt;
  logic        fire;
  logic        rearm;
  logic        win;
  logic        stale;

  assign dt    = now_ms - last_r;
  assign fire  = !gate_r && (raw >= $signed({cfg.high[15], cfg.high}));
  assign rearm = gate_r && (raw <= $signed({cfg.low[15], cfg.low}));
  assign win   = (dt > {16'b0, cfg.min_ms}) && (dt < {16'b0, cfg.max_ms});
  assign stale = dt > {16'b0, cfg.timeout_ms};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_r <= 1'b0;
      last_r <= '0;
      res_r  <= '0;
    end else if (upd) begin
      res_r.cap <= bank_one && fire && win;
      res_r.dt  <= dt[15:0];
      if (bank_one) begin
        if (fire) begin
          gate_r      <= 1'b1;
          last_r      <= now_ms;
          res_r.valid <= win || res_r.valid;
        end else begin
          if (rearm) begin
            gate_r <= 1'b0;
          end
          res_r.valid <= res_r.valid && !stale;
        end
      end else begin
        res_r.valid <= 1'b0;
      end
    end
  end

endmodule

FILE: hdl/control_input_conditioner_core.sv
// channel  | direction | handshake             | payload
// in_      | input     | in_valid / in_stall   | five adc codes, bank, patch, now_ms
// out_     | output    | out_valid / out_stall | knobs, mix, takeover, tap, bars_moved
// cfg_     | input     | cfg_wr_en             | cfg_index, cfg_wr_data
// One beat accepted per cycle while in_stall is low; each beat passes through the input register,
// filter/tap stage, two multiply stages and output register before it reaches the output.
// The pipeline has five stages and sustains one beat per clock while out_stall is low.
// Reset is synchronous on rst_n; no clearing pass, the block is ready the cycle after.
// out_stall backs up stage by stage; in_stall rises only when every stage is full.
module control_input_conditioner_core (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_adc_mix,
  input  logic [15:0] in_adc_pot_two,
  input  logic [15:0] in_adc_pot_three,
  input  logic [15:0] in_adc_cv_one,
  input  logic [15:0] in_adc_cv_two,
  input  logic [1:0]  in_bank,
  input  logic [1:0]  in_patch,
  input  logic [31:0] in_now_ms,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_knob_one,
  output logic [15:0] out_knob_two,
  output logic [15:0] out_knob_three,
  output logic [15:0] out_mix_level,
  output logic        out_cv_one_active,
  output logic        out_cv_two_active,
  output logic        out_tap_active,
  output logic [18:0] out_tap_delay_samples,
  output logic        out_bars_moved,

  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [17:0] cfg_wr_data
);
  import cic_pkg::*;

  // config
  logic [17:0] sample_rate_r;
  logic [15:0] to_on_r;
  logic [15:0] to_off_r;
  tap_cfg_t    tap_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_rate_r        <= 18'd48000;
      to_on_r              <= 16'd983;
      to_off_r             <= 16'd1966;
      tap_cfg_r.high       <= 16'd6144;
      tap_cfg_r.low        <= 16'd4096;
      tap_cfg_r.min_ms     <= 16'd50;
      tap_cfg_r.max_ms     <= 16'd2000;
      tap_cfg_r.timeout_ms <= 16'd1800;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SAMPLE_RATE:  sample_rate_r        <= cfg_wr_data;
        REG_TAKEOVER_ON:  to_on_r              <= cfg_wr_data[15:0];
        REG_TAKEOVER_OFF: to_off_r             <= cfg_wr_data[15:0];
        REG_TAP_HIGH:     tap_cfg_r.high       <= cfg_wr_data[15:0];
        REG_TAP_LOW:      tap_cfg_r.low        <= cfg_wr_data[15:0];
        REG_TAP_MIN:      tap_cfg_r.min_ms     <= cfg_wr_data[15:0];
        REG_TAP_MAX:      tap_cfg_r.max_ms     <= cfg_wr_data[15:0];
        REG_TAP_TIMEOUT:  tap_cfg_r.timeout_ms <= cfg_wr_data[15:0];
      endcase
    end
  end

  // stage flow
  logic v0_r, v1_r, v2_r, v3_r, v4_r;
  logic ld0, ld1, ld2, ld3, ld4;
  logic upd0, upd1, upd2, upd3, upd4;

  assign ld4  = !v4_r || !out_stall;
  assign ld3  = !v3_r || ld4;
  assign ld2  = !v2_r || ld3;
  assign ld1  = !v1_r || ld2;
  assign ld0  = !v0_r || ld1;
  assign upd0 = ld0 && in_valid;
  assign upd1 = ld1 && v0_r;
  assign upd2 = ld2 && v1_r;
  assign upd3 = ld3 && v2_r;
  assign upd4 = ld4 && v3_r;

  assign in_stall  = !ld0;
  assign out_valid = v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (ld0) v0_r <= in_valid;
      if (ld1) v1_r <= v0_r;
      if (ld2) v2_r <= v1_r;
      if (ld3) v3_r <= v2_r;
      if (ld4) v4_r <= v3_r;
    end
  end

  // stage 0: input register
  logic [15:0] s0_mix_r, s0_pot2_r, s0_pot3_r, s0_cv1_r, s0_cv2_r;
  logic [1:0]  s0_bank_r, s0_patch_r;
  logic [31:0] s0_now_r;

  always_ff @(posedge clk) begin
    if (upd0) begin
      s0_mix_r   <= in_adc_mix;
      s0_pot2_r  <= in_adc_pot_two;
      s0_pot3_r  <= in_adc_pot_three;
      s0_cv1_r   <= in_adc_cv_one;
      s0_cv2_r   <= in_adc_cv_two;
      s0_bank_r  <= in_bank;
      s0_patch_r <= in_patch;
      s0_now_r   <= in_now_ms;
    end
  end

  // stage 1: smoothing, tap gate and third-knob table lookup; filter states double as stage data
  logic signed [16:0] raw1, raw2;
  logic signed [24:0] mix_s_r, pot2_s_r, pot3_s_r, cv1_s_r, cv2_s_r;
  tap_res_t           tap_r;
  logic [15:0]        s1_knob3_r;

  assign raw1 = code_to_volts(s0_cv1_r);
  assign raw2 = code_to_volts(s0_cv2_r);

  cic_iir u_mix (.clk, .rst_n, .upd(upd1), .x({1'b0, ~s0_mix_r, 8'h00}),
                 .alpha(POT_ALPHA), .s_r(mix_s_r));
  cic_iir u_pot2 (.clk, .rst_n, .upd(upd1), .x({1'b0, ~s0_pot2_r, 8'h00}),
                  .alpha(POT_ALPHA), .s_r(pot2_s_r));
  cic_iir u_pot3 (.clk, .rst_n, .upd(upd1), .x({1'b0, ~s0_pot3_r, 8'h00}),
                  .alpha(POT_ALPHA), .s_r(pot3_s_r));
  cic_iir u_cv1 (.clk, .rst_n, .upd(upd1), .x({raw1, 8'h00}),
                 .alpha(CV1_ALPHA), .s_r(cv1_s_r));
  cic_iir u_cv2 (.clk, .rst_n, .upd(upd1), .x({raw2, 8'h00}),
                 .alpha(CV2_ALPHA), .s_r(cv2_s_r));

  cic_tap u_tap (
    .clk,
    .rst_n,
    .upd      (upd1),
    .bank_one (s0_bank_r == 2'd1),
    .raw      (raw2),
    .now_ms   (s0_now_r),
    .cfg      (tap_cfg_r),
    .res_r    (tap_r)
  );

  always_ff @(posedge clk) begin
    if (upd1) begin
      s1_knob3_r <= THIRD_TABLE[{s0_bank_r, s0_patch_r}];
    end
  end

  // stage 2: takeover, bars moved, unipolar and tap multiplies
  logic [15:0]        pm, p2, p3;
  logic [1:0]         flags_r, flags_nxt;
  logic [15:0]        drawn_r [3];
  logic               drawn_vld_r;
  logic [15:0]        lvl [3];
  logic               moved;
  logic signed [25:0] t1, t2;
  logic [38:0]        prod1, prod2;
  logic [33:0]        prod_t;

  logic [15:0] s2_pm_r, s2_p2_r, s2_p3_r, s2_knob3_r;
  logic        s2_tapv_r, s2_moved_r, s2_pos1_r, s2_pos2_r, s2_cap_r;
  logic [38:0] s2_prod1_r, s2_prod2_r;
  logic [33:0] s2_prod_t_r;

  assign pm = mix_s_r[23:8];
  assign p2 = pot2_s_r[23:8];
  assign p3 = pot3_s_r[23:8];

  always_comb begin
    flags_nxt = flags_r;
    if (!flags_r[0] && p2 <= to_on_r) flags_nxt[0] = 1'b1;
    else if (flags_r[0] && p2 >= to_off_r) flags_nxt[0] = 1'b0;
    if (!flags_r[1] && p3 <= to_on_r) flags_nxt[1] = 1'b1;
    else if (flags_r[1] && p3 >= to_off_r) flags_nxt[1] = 1'b0;
  end

  always_comb begin
    lvl[0] = pm;
    lvl[1] = p2;
    lvl[2] = p3;
    moved  = !drawn_vld_r;
    for (int i = 0; i < 3; i++) begin
      if (((lvl[i] > drawn_r[i]) ? lvl[i] - drawn_r[i] : drawn_r[i] - lvl[i]) > MOVE_LIMIT)
        moved = 1'b1;
    end
  end

  // (s + 5 V) / 160 as ((s + 5 V) >> 5) / 5
  assign t1     = {cv1_s_r[24], cv1_s_r} + CV_BIAS;
  assign t2     = {cv2_s_r[24], cv2_s_r} + CV_BIAS;
  assign prod1  = 39'(t1[23:5]) * 39'(RECIP5);
  assign prod2  = 39'(t2[23:5]) * 39'(RECIP5);
  assign prod_t = 34'(tap_r.dt) * 34'(sample_rate_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r     <= '0;
      drawn_vld_r <= 1'b0;
    end else if (upd2) begin
      flags_r <= flags_nxt;
      if (moved) drawn_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (upd2) begin
      if (moved) begin
        for (int i = 0; i < 3; i++) drawn_r[i] <= lvl[i];
      end
      s2_pm_r     <= pm;
      s2_p2_r     <= p2;
      s2_p3_r     <= p3;
      s2_knob3_r  <= s1_knob3_r;
      s2_tapv_r   <= tap_r.valid;
      s2_moved_r  <= moved;
      s2_pos1_r   <= !t1[25] && (t1 != '0);
      s2_pos2_r   <= !t2[25] && (t2 != '0);
      s2_prod1_r  <= prod1;
      s2_prod2_r  <= prod2;
      s2_cap_r    <= tap_r.cap;
      s2_prod_t_r <= prod_t;
    end
  end

  // stage 3: knob select, divide by 1000 reciprocal multiply
  logic [16:0] q1, q2;
  logic [15:0] u1, u2;
  logic [34:0] n_t;
  logic [25:0] m_t;
  logic [51:0] prod_d;

  logic [15:0] s3_k1_r, s3_k2_r, s3_pm_r, s3_knob3_r;
  logic [1:0]  s3_flags_r;
  logic        s3_tapv_r, s3_moved_r, s3_cap_r, s3_sat_r;
  logic [25:0] s3_m_r;
  logic [51:0] s3_prod_d_r;

  assign q1     = s2_prod1_r[38:22];
  assign q2     = s2_prod2_r[38:22];
  assign u1     = !s2_pos1_r ? 16'd0 : (q1[16] ? 16'hFFFF : q1[15:0]);
  assign u2     = !s2_pos2_r ? 16'd0 : (q2[16] ? 16'hFFFF : q2[15:0]);
  assign n_t    = {1'b0, s2_prod_t_r} + ROUND_HALF;
  assign m_t    = n_t[28:3];
  assign prod_d = 52'(m_t) * 52'(RECIP125);

  always_ff @(posedge clk) begin
    if (upd3) begin
      s3_k1_r     <= flags_r[0] ? u1 : s2_p2_r;
      s3_k2_r     <= flags_r[1] ? u2 : s2_p3_r;
      s3_pm_r     <= s2_pm_r;
      s3_knob3_r  <= s2_knob3_r;
      s3_flags_r  <= flags_r;
      s3_tapv_r   <= s2_tapv_r;
      s3_moved_r  <= s2_moved_r;
      s3_cap_r    <= s2_cap_r;
      s3_sat_r    <= n_t >= SAT_LIMIT;
      s3_m_r      <= m_t;
      s3_prod_d_r <= prod_d;
    end
  end

  // stage 4: quotient correction, output register
  logic [18:0] q0;
  logic [25:0] q0x;
  logic [25:0] rem;
  logic [18:0] quot;
  logic [18:0] interval_r;
  logic [15:0] o_k1_r, o_k2_r, o_k3_r, o_mix_r;
  logic [1:0]  o_flags_r;
  logic        o_tapv_r, o_moved_r;

  assign q0   = s3_prod_d_r[50:32];
  assign q0x  = 26'(q0) * DIV_STEP;
  assign rem  = s3_m_r - q0x;
  assign quot = q0 + 19'(rem >= DIV_STEP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= INTERVAL_RST;
    end else if (upd4 && s3_cap_r) begin
      interval_r <= s3_sat_r ? SAMPLES_MAX : quot;
    end
  end

  always_ff @(posedge clk) begin
    if (upd4) begin
      o_k1_r    <= s3_k1_r;
      o_k2_r    <= s3_k2_r;
      o_k3_r    <= s3_knob3_r;
      o_mix_r   <= s3_pm_r;
      o_flags_r <= s3_flags_r;
      o_tapv_r  <= s3_tapv_r;
      o_moved_r <= s3_moved_r;
    end
  end

  assign out_knob_one          = o_k1_r;
  assign out_knob_two          = o_k2_r;
  assign out_knob_three        = o_k3_r;
  assign out_mix_level         = o_mix_r;
  assign out_cv_one_active     = o_flags_r[0];
  assign out_cv_two_active     = o_flags_r[1];
  assign out_tap_active        = o_tapv_r;
  assign out_tap_delay_samples = interval_r;
  assign out_bars_moved        = o_moved_r;

endmodule

FILE: hdl/cic_chk.sv
module cic_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [15:0] in_adc_mix,
  input logic [15:0] in_adc_pot_two,
  input logic [15:0] in_adc_pot_three,
  input logic [15:0] in_adc_cv_one,
  input logic [15:0] in_adc_cv_two,
  input logic [1:0]  in_bank,
  input logic [1:0]  in_patch,
  input logic [31:0] in_now_ms,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_knob_one,
  input logic [15:0] out_knob_two,
  input logic [15:0] out_knob_three,
  input logic [15:0] out_mix_level,
  input logic        out_cv_one_active,
  input logic        out_cv_two_active,
  input logic        out_tap_active,
  input logic [18:0] out_tap_delay_samples,
  input logic        out_bars_moved,
  input logic        cfg_wr_en,
  input logic [2:0]  cfg_index,
  input logic [17:0] cfg_wr_data
);

  // reset empties the pipe and opens the input
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("pipe not empty after reset");

  // input backs up only when the output beat is held
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

  // a held beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_knob_one) && $stable(out_knob_two)
      && $stable(out_knob_three) && $stable(out_mix_level)
      && $stable(out_tap_delay_samples) && $stable(out_tap_active)
      && $stable(out_bars_moved) && $stable(out_cv_one_active)
      && $stable(out_cv_two_active))
    else $error("held output beat changed");

endmodule

bind control_input_conditioner_core cic_chk u_cic_chk (.*);
